// File: hdl/cft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Checksum frame transmitter package
// Shared widths, register indexes, the byte phase type and the request type
// passed from the front end to the byte emitter.
// ----------------------------------------------------------------------------
package cft_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned SIZE_W      = 16;
  localparam int unsigned CFG_IDX_W   = 8;
  localparam int unsigned CFG_DATA_W  = 8;

  localparam logic [BYTE_W-1:0] HEADER_OVERHEAD = 8'd4;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_ID       = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_LENGTH = 8'd1;

  localparam logic [BYTE_W-1:0] FRAME_ID_RST       = 8'd0;
  localparam logic [BYTE_W-1:0] PAYLOAD_LENGTH_RST = 8'd1;

  typedef enum logic [2:0] {
    PH_ID,
    PH_SIZE_LO,
    PH_SIZE_HI,
    PH_DATA,
    PH_CSUM
  } phase_e;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              hdr;
    logic              last;
  } item_t;

endpackage

// File: hdl/cft_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Checksum frame transmitter channels
// Payload input, byte output and configuration write channels.
// ----------------------------------------------------------------------------
interface cft_in_if;
  import cft_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface cft_out_if;
  import cft_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] tx_byte;
  logic              end_of_frame;
  modport source (output valid, output tx_byte, output end_of_frame, input ready);
  modport sink   (input valid, input tx_byte, input end_of_frame, output ready);
endinterface

interface cft_cfg_if;
  import cft_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

// File: hdl/cft_emitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Checksum frame transmitter byte emitter
// Holds one request and walks it through its header, data and checksum
// bytes into the output register, keeping the running frame sum.
// ----------------------------------------------------------------------------
module cft_emitter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_valid_i,
  output logic                          req_ready_o,
  input  cft_pkg::item_t                req_i,
  input  logic [cft_pkg::BYTE_W-1:0]    frame_id_i,
  input  logic [cft_pkg::SIZE_W-1:0]    frame_size_i,
  cft_out_if.source                     out_o
);
  import cft_pkg::*;

  logic              item_valid_q, item_valid_d;
  item_t             item_q, item_d;
  phase_e            phase_q, phase_d;
  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] tx_q, tx_d;
  logic              eof_q, eof_d;
  logic [BYTE_W-1:0] sum_q, sum_d;
  logic              load;
  logic              item_done;
  logic [BYTE_W-1:0] cur_byte;

  assign load = item_valid_q && (!out_valid_q || out_o.ready);

  always_comb begin
    case (phase_q)
      PH_ID:      cur_byte = frame_id_i;
      PH_SIZE_LO: cur_byte = frame_size_i[BYTE_W-1:0];
      PH_SIZE_HI: cur_byte = frame_size_i[SIZE_W-1:BYTE_W];
      PH_DATA:    cur_byte = item_q.data;
      PH_CSUM:    cur_byte = sum_q;
      default:    cur_byte = item_q.data;
    endcase
  end

  assign item_done = load && ((phase_q == PH_DATA && !item_q.last) || phase_q == PH_CSUM);
  assign req_ready_o = !item_valid_q || item_done;

  always_comb begin
    item_valid_d = item_valid_q;
    item_d       = item_q;
    phase_d      = phase_q;
    out_valid_d  = out_valid_q;
    tx_d         = tx_q;
    eof_d        = eof_q;
    sum_d        = sum_q;

    if (load) begin
      out_valid_d = 1'b1;
      tx_d        = cur_byte;
      eof_d       = (phase_q == PH_CSUM);
      case (phase_q)
        PH_ID:      sum_d = cur_byte;
        PH_CSUM:    sum_d = '0;
        default:    sum_d = sum_q + cur_byte;
      endcase
      case (phase_q)
        PH_ID:      phase_d = PH_SIZE_LO;
        PH_SIZE_LO: phase_d = PH_SIZE_HI;
        PH_SIZE_HI: phase_d = PH_DATA;
        PH_DATA:    phase_d = item_q.last ? PH_CSUM : PH_DATA;
        default:    phase_d = PH_DATA;
      endcase
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end

    if (item_done) begin
      item_valid_d = 1'b0;
    end

    if (req_valid_i && req_ready_o) begin
      item_valid_d = 1'b1;
      item_d       = req_i;
      phase_d      = req_i.hdr ? PH_ID : PH_DATA;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      phase_q      <= PH_DATA;
      out_valid_q  <= 1'b0;
      sum_q        <= '0;
    end else begin
      item_valid_q <= item_valid_d;
      phase_q      <= phase_d;
      out_valid_q  <= out_valid_d;
      sum_q        <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    tx_q   <= tx_d;
    eof_q  <= eof_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.tx_byte      = tx_q;
  assign out_o.end_of_frame = eof_q;

  a_csum_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_q && phase_q == PH_CSUM |-> item_q.last)
    else $error("checksum phase on a request that does not close the frame");

  a_hdr_only_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_q && (phase_q == PH_ID || phase_q == PH_SIZE_LO || phase_q == PH_SIZE_HI)
    |-> item_q.hdr)
    else $error("header phase on a request that does not open a frame");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !item_valid_q |-> req_ready_o)
    else $error("request refused while the emitter is empty");

  a_sum_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && phase_q == PH_CSUM |=> sum_q == '0 && out_valid_q && eof_q)
    else $error("frame sum not cleared after the checksum byte");

endmodule

// File: hdl/checksum_frame_transmitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Checksum frame transmitter
// Frames payload bytes with an ID byte, a 16-bit size and an additive
// checksum, sending one byte per cycle on the output channel while the
// receiver is ready. An accepted payload byte passes through the emitter's
// request register and then its output byte register, behind the frame header
// when it opens a frame. Throughput: one payload byte per cycle while the
// receiver is ready; the input is held while the header and checksum go out.
// Reset clears the frame position and sum and loads the register defaults.
// ----------------------------------------------------------------------------
module checksum_frame_transmitter (
  input  logic       clk_i,
  input  logic       rst_ni,
  cft_in_if.sink     in_i,
  cft_out_if.source  out_o,
  cft_cfg_if.sink    cfg_i
);
  import cft_pkg::*;

  logic [BYTE_W-1:0] frame_id_q;
  logic [BYTE_W-1:0] payload_length_q;
  logic [BYTE_W-1:0] count_q, count_d;
  logic [BYTE_W-1:0] len_eff;
  logic [BYTE_W:0]   done;
  logic [SIZE_W-1:0] frame_size;
  logic              in_accept;
  item_t             req;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_id_q       <= FRAME_ID_RST;
      payload_length_q <= PAYLOAD_LENGTH_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_FRAME_ID:       frame_id_q       <= cfg_i.wdata;
        REG_PAYLOAD_LENGTH: payload_length_q <= cfg_i.wdata;
        default:            ;
      endcase
    end
  end

  // A programmed length of zero behaves as a length of one.
  assign len_eff    = (payload_length_q == '0) ? BYTE_W'(1) : payload_length_q;
  assign frame_size = SIZE_W'(len_eff) + SIZE_W'(HEADER_OVERHEAD);
  assign done       = {1'b0, count_q} + (BYTE_W+1)'(1);

  assign req.data = in_i.data_byte;
  assign req.hdr  = (count_q == '0);
  assign req.last = (done >= {1'b0, len_eff});

  assign in_accept = in_i.valid && in_i.ready;
  assign count_d   = req.last ? '0 : done[BYTE_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (in_accept) begin
      count_q <= count_d;
    end
  end

  cft_emitter u_emitter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (in_i.valid),
    .req_ready_o  (in_i.ready),
    .req_i        (req),
    .frame_id_i   (frame_id_q),
    .frame_size_i (frame_size),
    .out_o        (out_o)
  );

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Checksum frame transmitter testbench
// Feeds payload bytes and register writes into the frame transmitter, predicts
// every emitted header, payload and checksum byte with a scoreboard, and
// checks the output stream in order under several sender and receiver
// idling profiles.
// ----------------------------------------------------------------------------
module tb;
  import cft_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] tx_byte;
    logic              end_of_frame;
  } link_byte_t;

  class frame_scoreboard;
    logic [BYTE_W-1:0] frame_id;
    logic [BYTE_W-1:0] payload_length;
    logic [BYTE_W-1:0] payload_count;
    logic [BYTE_W-1:0] running_sum;
    link_byte_t        link_expected[$];
    int                mismatches;

    function new();
      frame_id       = FRAME_ID_RST;
      payload_length = PAYLOAD_LENGTH_RST;
      payload_count  = '0;
      running_sum    = '0;
      mismatches     = 0;
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] wdata);
      if (index == REG_FRAME_ID) begin
        frame_id = wdata;
      end else if (index == REG_PAYLOAD_LENGTH) begin
        payload_length = wdata;
      end
    endfunction

    function void push_summed(logic [BYTE_W-1:0] b);
      running_sum = running_sum + b;
      link_expected.push_back('{tx_byte: b, end_of_frame: 1'b0});
    endfunction

    function void note_payload(logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0] eff_len;
      logic [SIZE_W-1:0] frame_size;
      eff_len = (payload_length == '0) ? 8'd1 : payload_length;
      if (payload_count == '0) begin
        frame_size  = SIZE_W'(eff_len) + SIZE_W'(HEADER_OVERHEAD);
        running_sum = '0;
        push_summed(frame_id);
        push_summed(frame_size[7:0]);
        push_summed(frame_size[15:8]);
      end
      push_summed(data);
      if ({1'b0, payload_count} + 9'd1 >= {1'b0, eff_len}) begin
        link_expected.push_back('{tx_byte: running_sum, end_of_frame: 1'b1});
        payload_count = '0;
        running_sum   = '0;
      end else begin
        payload_count = payload_count + 8'd1;
      end
    endfunction

    function void check_tx(logic [BYTE_W-1:0] tx_byte, logic end_of_frame);
      link_byte_t exp_byte;
      if (link_expected.size() == 0) begin
        $display("%0t: unexpected output, expected none, actual tx_byte %02h end_of_frame %0d",
                 $time, tx_byte, end_of_frame);
        mismatches++;
      end else begin
        exp_byte = link_expected.pop_front();
        if (exp_byte.tx_byte !== tx_byte) begin
          $display("%0t: tx_byte expected %02h actual %02h", $time, exp_byte.tx_byte, tx_byte);
          mismatches++;
        end
        if (exp_byte.end_of_frame !== end_of_frame) begin
          $display("%0t: end_of_frame expected %0d actual %0d",
                   $time, exp_byte.end_of_frame, end_of_frame);
          mismatches++;
        end
      end
    endfunction

    function int pending();
      return link_expected.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  int   idle_pct;
  int   stall_pct;

  frame_scoreboard frame_sb;

  cft_in_if  in_ch();
  cft_out_if out_ch();
  cft_cfg_if cfg_ch();

  checksum_frame_transmitter u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  initial begin
    clk_i = 1'b0;
  end

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        frame_sb.check_tx(out_ch.tx_byte, out_ch.end_of_frame);
      end
      if (in_ch.valid && in_ch.ready) begin
        frame_sb.note_payload(in_ch.data_byte);
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        frame_sb.note_config(cfg_ch.index, cfg_ch.wdata);
      end
    end
  end

  task automatic send_payload(logic [BYTE_W-1:0] data);
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= data;
    @(posedge clk_i);
    while (!in_ch.ready) begin
      @(posedge clk_i);
    end
    if ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      do begin
        @(posedge clk_i);
      end while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic send_frame_bytes(int count);
    for (int i = 0; i < count; i++) begin
      send_payload(BYTE_W'($urandom_range(255)));
    end
    in_ch.valid <= 1'b0;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] wdata);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.wdata <= wdata;
    @(posedge clk_i);
    while (!cfg_ch.ready) begin
      @(posedge clk_i);
    end
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    while (frame_sb.pending() > 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic send_list(logic [BYTE_W-1:0] bytes[$]);
    foreach (bytes[i]) begin
      send_payload(bytes[i]);
    end
    in_ch.valid <= 1'b0;
  endtask

  initial begin
    int items_left;
    int burst;
    int pick;
    frame_sb        = new();
    idle_pct        = 0;
    stall_pct       = 0;
    rst_ni          = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    out_ch.ready    = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = REG_FRAME_ID;
    cfg_ch.wdata    = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset defaults: one-byte frames with identifier zero.
    send_list('{8'h00, 8'hFF});
    wait_drained();

    // Largest identifier; the checksum wraps past 255.
    write_reg(REG_FRAME_ID, 8'hFF);
    write_reg(REG_PAYLOAD_LENGTH, 8'd3);
    send_list('{8'h80, 8'h01, 8'h7F});
    wait_drained();

    // A zero length behaves as a length of one.
    write_reg(REG_FRAME_ID, 8'h00);
    write_reg(REG_PAYLOAD_LENGTH, 8'd0);
    send_list('{8'hAA, 8'h55});
    wait_drained();

    // Largest length puts a nonzero high size byte in the header, then the
    // length is cut below the bytes already sent, so the next byte closes it.
    write_reg(REG_FRAME_ID, 8'h5A);
    write_reg(REG_PAYLOAD_LENGTH, 8'd255);
    send_list('{8'h12, 8'hED, 8'h33});
    wait_drained();
    write_reg(REG_PAYLOAD_LENGTH, 8'd2);
    send_list('{8'hC4});
    wait_drained();

    // Length lowered to exactly the bytes already sent.
    write_reg(REG_PAYLOAD_LENGTH, 8'd5);
    send_list('{8'h01, 8'h02});
    wait_drained();
    write_reg(REG_PAYLOAD_LENGTH, 8'd2);
    send_list('{8'h04});
    wait_drained();

    // Identifier changed mid-frame shows up only in the next header.
    write_reg(REG_PAYLOAD_LENGTH, 8'd3);
    send_list('{8'h10});
    wait_drained();
    write_reg(REG_FRAME_ID, 8'h3C);
    send_list('{8'h20, 8'h40, 8'h08});
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 50; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 50; end
        default: begin idle_pct = 27; stall_pct = 27; end
      endcase
      items_left = 48;
      while (items_left > 0) begin
        wait_drained();
        if ($urandom_range(99) < 60) begin
          pick = $urandom_range(99);
          write_reg(REG_FRAME_ID, (pick < 10) ? 8'h00 : (pick < 20) ? 8'hFF
                                  : CFG_DATA_W'($urandom_range(255)));
        end
        if ($urandom_range(99) < 60) begin
          pick = $urandom_range(99);
          write_reg(REG_PAYLOAD_LENGTH, (pick < 6) ? 8'd0 : (pick < 12) ? 8'd255
                                        : CFG_DATA_W'($urandom_range(1, 12)));
        end
        burst = $urandom_range(1, 16);
        if (burst > items_left) begin
          burst = items_left;
        end
        send_frame_bytes(burst);
        items_left -= burst;
      end
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (frame_sb.mismatches == 0 && frame_sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("tb: failure");
    $finish;
  end

endmodule
